FILE: hw/rtl/mvcc_pkg.sv
package mvcc_pkg;

   localparam int IdWidth    = 32;
   localparam int HintWidth  = 16;
   localparam int IndexWidth = 16;
   localparam int CountWidth = 17;

   typedef enum logic [1:0] {
      VERDICT_VISIBLE   = 2'd0,
      VERDICT_INVISIBLE = 2'd1,
      VERDICT_UNDECIDED = 2'd2
   } verdict_type;

   typedef enum logic {
      CSR_SNAPSHOT_LOW  = 1'b0,
      CSR_SNAPSHOT_HIGH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [HintWidth-1:0] hint_mask;
      logic [IdWidth-1:0]   insert_id;
      logic [IdWidth-1:0]   delete_id;
      logic                 last_in_batch;
   } req_word_type;

   typedef struct packed {
      logic [IndexWidth-1:0] tuple_index;
      logic [1:0]            verdict;
      logic [CountWidth-1:0] visible_count;
      logic [CountWidth-1:0] undecided_count;
      logic                  batch_done;
   } rsp_word_type;

   typedef struct packed {
      logic [IdWidth-1:0] low_id;
      logic [IdWidth-1:0] high_id;
   } snapshot_type;

endpackage

FILE: hw/rtl/mvcc_tuple_visibility_classifier.sv
// Channel  Ports                          Direction  Word
// request  req_valid req_stall req_word   in         hint_mask, insert_id, delete_id, last
// response rsp_valid rsp_stall rsp_word   out        index, verdict, counts, batch_done
// csr      csr_wr_en csr_index csr_data   in         snapshot low / high id
//
// One word per cycle sustained while rsp_stall is low; path: input register, then result register.
// Classification is a single combinational pass between the two registers.
// Synchronous reset clears valids, batch position and counts; snapshot ids reset to 0.
// A stalled result register holds the input register, which then stalls the request side.
module mvcc_tuple_visibility_classifier #(
   parameter int MAX_BATCH = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mvcc_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mvcc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [31:0]            csr_data
);
   import mvcc_pkg::*;

   snapshot_type snapshot_ff, snapshot_in;
   req_word_type req_word_ff;
   logic         req_valid_ff, req_valid_in;
   logic         req_accept, stage_ready;
   verdict_type  verdict;

   always_comb begin
      snapshot_in = snapshot_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SNAPSHOT_LOW:  snapshot_in.low_id  = csr_data;
            CSR_SNAPSHOT_HIGH: snapshot_in.high_id = csr_data;
         endcase
      end
   end

   always_comb begin
      req_stall    = req_valid_ff && !stage_ready;
      req_accept   = req_valid && !req_stall;
      req_valid_in = req_accept || (req_valid_ff && !stage_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snapshot_ff  <= '0;
         req_valid_ff <= 1'b0;
      end else begin
         snapshot_ff  <= snapshot_in;
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_word_ff <= req_word;
      end
   end

   mvcc_classify u_classify (
      .snapshot  (snapshot_ff),
      .hint_mask (req_word_ff.hint_mask),
      .insert_id (req_word_ff.insert_id),
      .delete_id (req_word_ff.delete_id),
      .verdict   (verdict)
   );

   mvcc_tally #(
      .MAX_BATCH (MAX_BATCH)
   ) u_tally (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid_ff),
      .in_last    (req_word_ff.last_in_batch),
      .in_verdict (verdict),
      .in_ready   (stage_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

FILE: hw/rtl/mvcc_classify.sv
module mvcc_classify (
   input  mvcc_pkg::snapshot_type snapshot,
   input  logic [15:0]            hint_mask,
   input  logic [31:0]            insert_id,
   input  logic [31:0]            delete_id,
   output mvcc_pkg::verdict_type  verdict
);
   import mvcc_pkg::*;

   localparam int HmKeyshrLock    = 4;
   localparam int HmExclLock      = 6;
   localparam int HmLockOnly      = 7;
   localparam int HmXminCommitted = 8;
   localparam int HmXminInvalid   = 9;
   localparam int HmXmaxCommitted = 10;
   localparam int HmXmaxInvalid   = 11;
   localparam int HmXmaxMulti     = 12;
   localparam int HmMovedOff      = 14;
   localparam int HmMovedIn       = 15;

   // wraparound-safe order: a precedes b when a - b is negative
   function automatic logic precedes(input logic [IdWidth-1:0] a,
                                     input logic [IdWidth-1:0] b);
      logic [IdWidth-1:0] diff;
      diff = a - b;
      return diff[IdWidth-1];
   endfunction

   logic not_moved, frozen, ins_aborted, xn_comm;
   logic ins_vis, ins_inv;
   logic x_inval, x_multi, x_comm, x_lock_only, x_void, eff;
   logic xn_before_low, xn_before_high, xx_before_low, xx_before_high;
   logic in_window, del_und, del_inv;

   always_comb begin
      not_moved   = !hint_mask[HmMovedOff] && !hint_mask[HmMovedIn];
      frozen      = hint_mask[HmXminCommitted] && hint_mask[HmXminInvalid];
      ins_aborted = !hint_mask[HmXminCommitted] && hint_mask[HmXminInvalid];
      xn_comm     = hint_mask[HmXminCommitted] && !hint_mask[HmXminInvalid];

      xn_before_low  = precedes(insert_id, snapshot.low_id);
      xn_before_high = precedes(insert_id, snapshot.high_id);
      xx_before_low  = precedes(delete_id, snapshot.low_id);
      xx_before_high = precedes(delete_id, snapshot.high_id);

      ins_vis = not_moved && (frozen || (xn_comm && xn_before_low));
      ins_inv = not_moved && (ins_aborted || (xn_comm && !xn_before_high));

      x_inval     = hint_mask[HmXmaxInvalid];
      x_multi     = hint_mask[HmXmaxMulti];
      x_comm      = hint_mask[HmXmaxCommitted];
      x_lock_only = hint_mask[HmLockOnly] ||
                    (hint_mask[HmExclLock] && !hint_mask[HmKeyshrLock] && !x_multi);
      x_void      = x_inval || x_lock_only;
      eff         = x_comm && !x_void && !x_multi;
      in_window   = eff && !xx_before_low && xx_before_high;
      del_und     = !x_void && (x_multi || !x_comm || in_window);
      del_inv     = eff && xx_before_low;

      if (!(ins_vis || ins_inv)) begin
         verdict = VERDICT_UNDECIDED;
      end else if (ins_inv) begin
         verdict = VERDICT_INVISIBLE;
      end else if (del_und) begin
         verdict = VERDICT_UNDECIDED;
      end else if (del_inv) begin
         verdict = VERDICT_INVISIBLE;
      end else begin
         verdict = VERDICT_VISIBLE;
      end
   end

endmodule

FILE: hw/rtl/mvcc_tally.sv
module mvcc_tally #(
   parameter int MAX_BATCH = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic                   in_last,
   input  mvcc_pkg::verdict_type  in_verdict,
   output logic                   in_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mvcc_pkg::rsp_word_type rsp_word
);
   import mvcc_pkg::*;

   localparam logic [IndexWidth:0] LastPos = (IndexWidth+1)'(MAX_BATCH - 1);

   logic [IndexWidth-1:0] position_ff, position_in;
   logic [CountWidth-1:0] visible_ff, visible_in;
   logic [CountWidth-1:0] undecided_ff, undecided_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  load, done;
   logic [CountWidth-1:0] visible_next, undecided_next;

   always_comb begin
      in_ready = !rsp_valid_ff || !rsp_stall;
      load     = in_valid && in_ready;
      done     = in_last || ({1'b0, position_ff} >= LastPos);

      visible_next   = visible_ff;
      undecided_next = undecided_ff;
      if (in_verdict == VERDICT_VISIBLE) begin
         visible_next = visible_ff + 1'b1;
      end
      if (in_verdict == VERDICT_UNDECIDED) begin
         undecided_next = undecided_ff + 1'b1;
      end

      rsp_word_in.tuple_index     = position_ff;
      rsp_word_in.verdict         = in_verdict;
      rsp_word_in.visible_count   = visible_next;
      rsp_word_in.undecided_count = undecided_next;
      rsp_word_in.batch_done      = done;

      position_in  = position_ff;
      visible_in   = visible_ff;
      undecided_in = undecided_ff;
      if (load) begin
         if (done) begin
            position_in  = '0;
            visible_in   = '0;
            undecided_in = '0;
         end else begin
            position_in  = position_ff + 1'b1;
            visible_in   = visible_next;
            undecided_in = undecided_next;
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         visible_ff   <= '0;
         undecided_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         position_ff  <= position_in;
         visible_ff   <= visible_in;
         undecided_ff <= undecided_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTHESIS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_word_ff.visible_count} + {1'b0, rsp_word_ff.undecided_count}
                        <= (CountWidth+1)'(rsp_word_ff.tuple_index) + 1'b1))
      else $error("batch counts exceed tuple position");

   a_open_batch_short: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.batch_done) |-> ({1'b0, rsp_word_ff.tuple_index} < LastPos))
      else $error("batch left open at its length limit");

   a_visible_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.verdict == VERDICT_VISIBLE)
         |-> (rsp_word_ff.visible_count != '0))
      else $error("visible word not counted");

   a_position_restart: assert property (@(posedge clock) disable iff (reset)
      (load && done) |=> (position_ff == '0 && visible_ff == '0 && undecided_ff == '0))
      else $error("batch state not restarted after close");
`endif

endmodule

FILE: test/mvcc_tuple_visibility_classifier_tb.sv
module mvcc_tuple_visibility_classifier_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mvcc_pkg::*;

   localparam logic [15:0] HINT_KEYSHR_LOCK    = 16'h0010;
   localparam logic [15:0] HINT_EXCL_LOCK      = 16'h0040;
   localparam logic [15:0] HINT_LOCK_ONLY      = 16'h0080;
   localparam logic [15:0] HINT_XMIN_COMMITTED = 16'h0100;
   localparam logic [15:0] HINT_XMIN_INVALID   = 16'h0200;
   localparam logic [15:0] HINT_XMIN_FROZEN    = 16'h0300;
   localparam logic [15:0] HINT_XMAX_COMMITTED = 16'h0400;
   localparam logic [15:0] HINT_XMAX_INVALID   = 16'h0800;
   localparam logic [15:0] HINT_XMAX_MULTI     = 16'h1000;
   localparam logic [15:0] HINT_MOVED_OFF      = 16'h4000;
   localparam logic [15:0] HINT_MOVED_IN       = 16'h8000;
   localparam int          BATCH_LIMIT         = 65536;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en = 1'b0;
   logic         csr_index = 1'b0;
   logic [31:0]  csr_data = '0;

   // visibility model state
   logic [31:0] snap_low = '0;
   logic [31:0] snap_high = '0;
   logic [15:0] batch_pos = '0;
   logic [16:0] vis_total = '0;
   logic [16:0] und_total = '0;

   rsp_word_type expected_words[$];
   int fail_count = 0;
   int words_checked = 0;
   int batches_closed = 0;
   int verdicts_seen[3] = '{0, 0, 0};

   // idling controls
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_len = 0;
   int stall_left = 0;

   mvcc_tuple_visibility_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic id_before(logic [31:0] a, logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   function automatic verdict_type visibility_of(logic [15:0] hint, logic [31:0] ins_id,
                                                 logic [31:0] del_id);
      logic [15:0] xmin_bits;
      logic not_moved, ins_vis, ins_inv, xmax_inval, xmax_multi, xmax_comm;
      logic lock_only, xmax_void, effective, del_early, del_window, del_und, del_inv;
      xmin_bits  = hint & HINT_XMIN_FROZEN;
      not_moved  = (hint & (HINT_MOVED_OFF | HINT_MOVED_IN)) == 0;
      ins_vis    = not_moved && (xmin_bits == HINT_XMIN_FROZEN ||
                   (xmin_bits == HINT_XMIN_COMMITTED && id_before(ins_id, snap_low)));
      ins_inv    = not_moved && (xmin_bits == HINT_XMIN_INVALID ||
                   (xmin_bits == HINT_XMIN_COMMITTED && !id_before(ins_id, snap_high)));
      xmax_inval = (hint & HINT_XMAX_INVALID) != 0;
      xmax_multi = (hint & HINT_XMAX_MULTI) != 0;
      xmax_comm  = (hint & HINT_XMAX_COMMITTED) != 0;
      lock_only  = (hint & HINT_LOCK_ONLY) != 0 ||
                   (hint & (HINT_XMAX_MULTI | HINT_KEYSHR_LOCK | HINT_EXCL_LOCK))
                      == HINT_EXCL_LOCK;
      xmax_void  = xmax_inval || lock_only;
      effective  = xmax_comm && !xmax_void && !xmax_multi;
      del_early  = id_before(del_id, snap_low);
      del_window = effective && !del_early && id_before(del_id, snap_high);
      del_und    = !xmax_void && (xmax_multi || !xmax_comm || del_window);
      del_inv    = effective && del_early;
      if (!(ins_vis || ins_inv)) return VERDICT_UNDECIDED;
      if (ins_inv) return VERDICT_INVISIBLE;
      if (del_und) return VERDICT_UNDECIDED;
      return del_inv ? VERDICT_INVISIBLE : VERDICT_VISIBLE;
   endfunction

   function automatic rsp_word_type classify_tuple(req_word_type w);
      rsp_word_type r;
      verdict_type v;
      logic closes;
      v = visibility_of(w.hint_mask, w.insert_id, w.delete_id);
      closes = w.last_in_batch || batch_pos == 16'(BATCH_LIMIT - 1);
      if (v == VERDICT_VISIBLE) vis_total = vis_total + 1'b1;
      else if (v == VERDICT_UNDECIDED) und_total = und_total + 1'b1;
      r.tuple_index     = batch_pos;
      r.verdict         = v;
      r.visible_count   = vis_total;
      r.undecided_count = und_total;
      r.batch_done      = closes;
      if (closes) begin
         batch_pos = '0;
         vis_total = '0;
         und_total = '0;
      end else begin
         batch_pos = batch_pos + 1'b1;
      end
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_word_type tuple(logic [15:0] hint, logic [31:0] ins_id,
                                          logic [31:0] del_id, logic last);
      req_word_type w;
      w.hint_mask     = hint;
      w.insert_id     = ins_id;
      w.delete_id     = del_id;
      w.last_in_batch = last;
      return w;
   endfunction

   function automatic logic [31:0] near_window_id();
      case ($urandom_range(0, 5))
         0: return snap_low + $urandom_range(0, 8) - 4;
         1: return snap_high + $urandom_range(0, 8) - 4;
         2: return snap_low + ((snap_high - snap_low) >> $urandom_range(1, 4));
         3: return snap_low - 32'h8000_0000 + $urandom_range(0, 4) - 2;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type random_tuple();
      logic [15:0] hint;
      hint = 16'($urandom) & 16'h202F;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: hint |= HINT_XMIN_COMMITTED;
         4, 5:       hint |= HINT_XMIN_FROZEN;
         6, 7:       hint |= HINT_XMIN_INVALID;
         default:    ;
      endcase
      if ($urandom_range(0, 15) == 0) hint |= 16'($urandom) & (HINT_MOVED_OFF | HINT_MOVED_IN);
      if ($urandom_range(0, 4) == 0) hint |= HINT_LOCK_ONLY;
      if ($urandom_range(0, 2) == 0) hint |= HINT_EXCL_LOCK;
      if ($urandom_range(0, 2) == 0) hint |= HINT_KEYSHR_LOCK;
      if ($urandom_range(0, 5) == 0) hint |= HINT_XMAX_MULTI;
      if ($urandom_range(0, 1) == 0) hint |= HINT_XMAX_COMMITTED;
      if ($urandom_range(0, 2) == 0) hint |= HINT_XMAX_INVALID;
      // some noise: any header at all
      if ($urandom_range(0, 9) == 0) hint = 16'($urandom);
      return tuple(hint, near_window_id(), near_window_id(), $urandom_range(0, 9) == 0);
   endfunction

   task automatic send_tuple(input req_word_type w);
      int n;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         n = gap_len();
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(classify_tuple(w));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_words.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(input logic [31:0] low_id, input logic [31:0] high_id);
      drain_pipeline();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SNAPSHOT_LOW;
      csr_data  <= low_id;
      @(posedge clock);
      csr_index <= CSR_SNAPSHOT_HIGH;
      csr_data  <= high_id;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      snap_low  = low_id;
      snap_high = high_id;
   endtask

   // receiver: random stalls plus an occasional long hold
   always @(posedge clock) begin
      if (hold_len > 0) begin
         stall_left = hold_len - 1;
         hold_len   = 0;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = gap_len() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("result word with none expected: %h", rsp_word);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            words_checked++;
            if (want.batch_done) batches_closed++;
            if (want.verdict < 3) verdicts_seen[want.verdict]++;
            if (rsp_word.tuple_index !== want.tuple_index) begin
               $error("tuple_index: expected %0d, got %0d", want.tuple_index,
                      rsp_word.tuple_index);
               fail_count++;
            end
            if (rsp_word.verdict !== want.verdict) begin
               $error("verdict: expected %0d, got %0d", want.verdict, rsp_word.verdict);
               fail_count++;
            end
            if (rsp_word.visible_count !== want.visible_count) begin
               $error("visible_count: expected %0d, got %0d", want.visible_count,
                      rsp_word.visible_count);
               fail_count++;
            end
            if (rsp_word.undecided_count !== want.undecided_count) begin
               $error("undecided_count: expected %0d, got %0d", want.undecided_count,
                      rsp_word.undecided_count);
               fail_count++;
            end
            if (rsp_word.batch_done !== want.batch_done) begin
               $error("batch_done: expected %0d, got %0d", want.batch_done,
                      rsp_word.batch_done);
               fail_count++;
            end
         end
      end
   end

   task automatic test_directed();
      set_window(32'd1000, 32'd2000);
      gap_pct   = 20;
      stall_pct = 20;
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_XMAX_INVALID, 32'd0, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_INVALID, 32'd500, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMAX_INVALID, 32'd500, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_COMMITTED | HINT_MOVED_OFF | HINT_XMAX_INVALID,
                       32'd500, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_COMMITTED | HINT_MOVED_IN | HINT_XMAX_INVALID,
                       32'd500, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_COMMITTED | HINT_XMAX_INVALID, 32'd1500, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_COMMITTED | HINT_XMAX_INVALID, 32'd999, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_COMMITTED | HINT_XMAX_INVALID, 32'd2000, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_COMMITTED | HINT_XMAX_INVALID, 32'hFFFF_FFFF, 32'd0, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_LOCK_ONLY | HINT_XMAX_COMMITTED,
                       32'd0, 32'd1500, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_EXCL_LOCK, 32'd0, 32'd1500, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_EXCL_LOCK | HINT_KEYSHR_LOCK |
                       HINT_XMAX_COMMITTED, 32'd0, 32'd1500, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_EXCL_LOCK | HINT_XMAX_MULTI |
                       HINT_XMAX_COMMITTED, 32'd0, 32'd500, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_XMAX_COMMITTED, 32'd0, 32'd500, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_XMAX_COMMITTED, 32'd0, 32'd1999, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_XMAX_COMMITTED, 32'd0, 32'd2000, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN, 32'd0, 32'd500, 1'b0));
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_XMAX_INVALID | HINT_XMAX_COMMITTED,
                       32'd0, 32'd500, 1'b1));
      send_tuple(tuple(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      send_tuple(tuple(16'h0000, 32'd0, 32'd0, 1'b1));
      // deleter id half the id space away wraps to "before"
      send_tuple(tuple(HINT_XMIN_FROZEN | HINT_XMAX_COMMITTED, 32'd0, 32'h8000_03E8, 1'b1));
   endtask

   task automatic test_random_windows();
      logic [31:0] lows[6];
      logic [31:0] highs[6];
      int base;
      base  = $urandom;
      lows  = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h8000_0000, base};
      highs = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'h0000_0100, 32'h7FFF_FFFF,
                base + $urandom_range(1, 5000)};
      for (int s = 0; s < 6; s++) begin
         set_window(lows[s], highs[s]);
         for (int i = 0; i < 135; i++) begin
            case (i / 40)
               0:       begin gap_pct = 0;  stall_pct = 0;  end
               1:       begin gap_pct = 30; stall_pct = 30; end
               2:       begin gap_pct = 60; stall_pct = 10; end
               default: begin gap_pct = 10; stall_pct = 60; end
            endcase
            send_tuple(random_tuple());
         end
      end
   endtask

   task automatic test_backpressure();
      set_window(32'd100, 32'd200);
      gap_pct   = 0;
      stall_pct = 0;
      hold_len  = 80;
      for (int i = 0; i < 40; i++) begin
         send_tuple(random_tuple());
      end
      send_tuple(tuple(HINT_XMIN_FROZEN, 32'd0, 32'd0, 1'b1));
   endtask

   task automatic test_long_batch();
      set_window(32'd5000, 32'd6000);
      gap_pct   = 0;
      stall_pct = 0;
      // every tuple visible, so the count climbs with the position
      for (int i = 0; i < 40; i++) begin
         send_tuple(tuple((16'($urandom) & 16'h3CFF) | HINT_XMIN_FROZEN | HINT_XMAX_INVALID,
                          $urandom, $urandom, 1'b0));
      end
      send_tuple(random_tuple());
      send_tuple(tuple(HINT_XMIN_INVALID, 32'd0, 32'd0, 1'b1));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_windows();
      test_backpressure();
      test_long_batch();
      drain_pipeline();
      repeat (10) @(posedge clock);
      $display("checked %0d result words over %0d closed batches", words_checked,
               batches_closed);
      $display("verdicts visible %0d, invisible %0d, undecided %0d, across 9 snapshot windows",
               verdicts_seen[0], verdicts_seen[1], verdicts_seen[2]);
      if (fail_count == 0) begin
         $display("mvcc_tuple_visibility_classifier test passed");
      end else begin
         $display("mvcc_tuple_visibility_classifier test failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("mvcc_tuple_visibility_classifier test failed");
      $finish;
   end

endmodule
